// File: design/srt_pkg.sv
// Shared types and constants for the slot record table.
`default_nettype none
package srt_pkg;

  localparam int SRT_TABLE_DEPTH = 64;

  localparam int CODE_W  = 32;
  localparam int PRICE_W = 34;
  localparam int QTY_W   = 10;
  localparam int SLOT_W  = 6;

  typedef enum logic [2:0] {
    REQ_INSERT    = 3'd0,
    REQ_DELETE    = 3'd1,
    REQ_LOOKUP    = 3'd2,
    REQ_SET_PRICE = 3'd3,
    REQ_SET_QTY   = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } srt_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic done;
  } srt_stat_t;

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } entry_t;

endpackage
`default_nettype wire

// File: design/srt_ctrl.sv
// Controller state machine for the slot record table.
`default_nettype none
module srt_ctrl
  import srt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire srt_stat_t stat,
  output srt_cmd_t       cmd,
  output logic           busy,
  output logic           out_valid
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  assign busy      = (state_r == S_SCAN);
  assign out_valid = (state_r == S_RESP);

  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.finish = 1'b0;
    case (state_r)
      S_IDLE, S_RESP: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat.done) begin
          cmd.finish = 1'b1;
          state_nxt  = S_RESP;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // The result strobe lasts a single cycle.
  a_resp_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RESP |=> state_r != S_RESP)
    else $error("result strobe held for more than one cycle");

  // A request is only taken when the block is not scanning.
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !busy && start)
    else $error("request loaded while busy");

endmodule
`default_nettype wire

// File: design/srt_dp.sv
// Datapath of the slot record table: request registers, entry memory, valid bits, scan.
`default_nettype none
module srt_dp
  import srt_pkg::*;
#(
  parameter int TABLE_DEPTH = SRT_TABLE_DEPTH
)
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire srt_cmd_t           cmd,
  output srt_stat_t               stat,
  input  wire logic [2:0]         in_req_type,
  input  wire logic [CODE_W-1:0]  in_product_code,
  input  wire logic [PRICE_W-1:0] in_price,
  input  wire logic [QTY_W-1:0]   in_quantity,
  output logic [1:0]              out_status,
  output logic [SLOT_W-1:0]       out_slot_index,
  output logic [CODE_W-1:0]       out_code_out,
  output logic [PRICE_W-1:0]      out_price_out,
  output logic [QTY_W-1:0]        out_quantity_out
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;
  localparam int SW = (AW > SLOT_W) ? AW : SLOT_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  // Request registers.
  logic [2:0]         req_r;
  logic [CODE_W-1:0]  code_r;
  logic [PRICE_W-1:0] price_r;
  logic [QTY_W-1:0]   qty_r;

  // Scan state.
  logic [CW-1:0]      cnt_r;
  logic               rd_vld_r;
  logic [AW-1:0]      rd_slot_r;
  logic               rd_live_r;
  entry_t             rd_data_r;

  logic [TABLE_DEPTH-1:0] valid_r;
  logic [CODE_W-1:0]      next_code_r;

  entry_t entry_mem [TABLE_DEPTH];

  logic [AW-1:0] scan_addr;
  logic          in_range;
  logic          is_ins, is_find, is_bad;
  logic          free_hit, full, find_hit, find_miss;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [AW-1:0] fin_slot;
  logic [SW-1:0] slot_ext;
  logic [1:0]    status_nxt;
  logic          ok;

  assign scan_addr = cnt_r[AW-1:0];
  assign in_range  = (cnt_r < DEPTH_C);

  always_comb begin
    is_ins  = 1'b0;
    is_find = 1'b0;
    is_bad  = 1'b0;
    case (req_r) inside
      REQ_INSERT:                                         is_ins  = 1'b1;
      REQ_DELETE, REQ_LOOKUP, REQ_SET_PRICE, REQ_SET_QTY: is_find = 1'b1;
      default:                                            is_bad  = 1'b1;
    endcase
  end

  assign free_hit  = is_ins && in_range && !valid_r[scan_addr];
  assign full      = is_ins && (cnt_r == DEPTH_C);
  assign find_hit  = is_find && rd_vld_r && rd_live_r && (rd_data_r.code == code_r);
  assign find_miss = is_find && (cnt_r == DEPTH_C) && !find_hit;
  assign stat.done = free_hit || full || find_hit || find_miss || is_bad;

  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = rd_slot_r;
    mem_wdata  = rd_data_r;
    fin_slot   = rd_slot_r;
    ok         = 1'b0;
    status_nxt = ST_NOT_FOUND;
    if (free_hit) begin
      ok              = 1'b1;
      status_nxt      = ST_OK;
      fin_slot        = scan_addr;
      mem_waddr       = scan_addr;
      mem_wdata.code  = next_code_r;
      mem_wdata.price = price_r;
      mem_wdata.qty   = qty_r;
      mem_we          = cmd.finish;
    end else if (find_hit) begin
      ok         = 1'b1;
      status_nxt = ST_OK;
      if (req_r == REQ_SET_PRICE) begin
        mem_wdata.price = price_r;
      end
      if (req_r == REQ_SET_QTY) begin
        mem_wdata.qty = qty_r;
      end
      mem_we = cmd.finish && ((req_r == REQ_SET_PRICE) || (req_r == REQ_SET_QTY));
    end else if (full) begin
      status_nxt = ST_FULL;
    end
  end

  assign slot_ext = SW'(fin_slot);

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= entry_mem[scan_addr];
  end

  // Request and result payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= in_req_type;
      code_r  <= in_product_code;
      price_r <= in_price;
      qty_r   <= in_quantity;
    end
    if (cmd.step) begin
      rd_slot_r <= scan_addr;
      rd_live_r <= valid_r[scan_addr];
    end
    if (cmd.finish) begin
      out_status       <= status_nxt;
      out_slot_index   <= ok ? slot_ext[SLOT_W-1:0] : '0;
      out_code_out     <= ok ? mem_wdata.code : '0;
      out_price_out    <= ok ? mem_wdata.price : '0;
      out_quantity_out <= ok ? mem_wdata.qty : '0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      valid_r     <= '0;
      next_code_r <= '0;
    end else begin
      if (cmd.load) begin
        cnt_r    <= '0;
        rd_vld_r <= 1'b0;
      end else if (cmd.step) begin
        rd_vld_r <= in_range;
        if (in_range) begin
          cnt_r <= cnt_r + CW'(1);
        end
      end
      if (cmd.finish) begin
        if (free_hit) begin
          valid_r[scan_addr] <= 1'b1;
          next_code_r        <= next_code_r + CODE_W'(1);
        end else if (find_hit && (req_r == REQ_DELETE)) begin
          valid_r[rd_slot_r] <= 1'b0;
        end
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("scan counter beyond table depth");

  a_insert_marks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && free_hit |=> valid_r[$past(scan_addr)])
    else $error("inserted slot not marked valid");

  a_code_steady: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.finish && free_hit) |=> $stable(next_code_r))
    else $error("code counter moved without an insert");

  a_finish_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> stat.done && !cmd.step)
    else $error("request finished before the scan settled");

endmodule
`default_nettype wire

// File: design/slot_record_table.sv
// Top level of the slot record table: controller and datapath joined together.
// Insert stops the scan at the first free slot; delete, lookup and modify stop it at the slot
// holding the code; table full and code not found scan the whole table; an unknown request
// type finishes without a scan. The scan reads one slot per cycle through the single read port
// of the entry memory, and a new beat is taken in the cycle of the strobe.
// Synchronous active-low reset empties every slot and sets the code counter to zero.
`default_nettype none
module slot_record_table
  import srt_pkg::*;
#(
  parameter int TABLE_DEPTH = SRT_TABLE_DEPTH
)
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_req_type,
  input  wire logic [CODE_W-1:0]  in_product_code,
  input  wire logic [PRICE_W-1:0] in_price,
  input  wire logic [QTY_W-1:0]   in_quantity,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic [SLOT_W-1:0]       out_slot_index,
  output logic [CODE_W-1:0]       out_code_out,
  output logic [PRICE_W-1:0]      out_price_out,
  output logic [QTY_W-1:0]        out_quantity_out
);

  // Commands run from the controller to the datapath; the datapath reports back a single
  // done flag when the scan finds its slot or runs off the end, or the request type is unknown.
  srt_cmd_t  cmd;
  srt_stat_t stat;

  // The controller sequences each beat: load the request, step the scan, then finish.
  srt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // The datapath holds the entry memory, valid bits and code counter, and registers the
  // result so that it is stable throughout the strobe cycle.
  srt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_req_type      (in_req_type),
    .in_product_code  (in_product_code),
    .in_price         (in_price),
    .in_quantity      (in_quantity),
    .out_status       (out_status),
    .out_slot_index   (out_slot_index),
    .out_code_out     (out_code_out),
    .out_price_out    (out_price_out),
    .out_quantity_out (out_quantity_out)
  );

endmodule
`default_nettype wire

// File: tb/table_scoreboard_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the slot record table: its own copy of the table and the queue of replies due.
package table_scoreboard_pkg;
  import srt_pkg::*;

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic [CODE_W-1:0]  code;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } table_reply_t;

  class table_scoreboard;
    bit                 held [SRT_TABLE_DEPTH];
    logic [CODE_W-1:0]  held_code [SRT_TABLE_DEPTH];
    logic [PRICE_W-1:0] held_price [SRT_TABLE_DEPTH];
    logic [QTY_W-1:0]   held_qty [SRT_TABLE_DEPTH];
    logic [CODE_W-1:0]  code_counter;
    table_reply_t       replies_due [$];
    int                 mismatches;

    function new();
      code_counter = '0;
      mismatches   = 0;
      foreach (held[s]) held[s] = 1'b0;
    endfunction

    function table_reply_t reply_for(status_t st, int slot);
      table_reply_t r;
      r        = '0;
      r.status = st;
      if (slot >= 0) begin
        r.slot  = slot[SLOT_W-1:0];
        r.code  = held_code[slot];
        r.price = held_price[slot];
        r.qty   = held_qty[slot];
      end
      return r;
    endfunction

    // Works out the reply to one accepted request and updates the table copy.
    function void note_request(logic [2:0] kind, logic [CODE_W-1:0] code,
                               logic [PRICE_W-1:0] price, logic [QTY_W-1:0] qty);
      int slot;
      slot = -1;
      if (kind == REQ_INSERT) begin
        for (int s = SRT_TABLE_DEPTH - 1; s >= 0; s--) if (!held[s]) slot = s;
        if (slot < 0) begin
          replies_due.push_back(reply_for(ST_FULL, -1));
        end else begin
          held[slot]       = 1'b1;
          held_code[slot]  = code_counter;
          held_price[slot] = price;
          held_qty[slot]   = qty;
          code_counter     = code_counter + 1'b1;
          replies_due.push_back(reply_for(ST_OK, slot));
        end
      end else if (kind > REQ_SET_QTY) begin
        replies_due.push_back(reply_for(ST_NOT_FOUND, -1));
      end else begin
        for (int s = SRT_TABLE_DEPTH - 1; s >= 0; s--) begin
          if (held[s] && held_code[s] == code) slot = s;
        end
        if (slot < 0) begin
          replies_due.push_back(reply_for(ST_NOT_FOUND, -1));
        end else begin
          if (kind == REQ_SET_PRICE) held_price[slot] = price;
          else if (kind == REQ_SET_QTY) held_qty[slot] = qty;
          replies_due.push_back(reply_for(ST_OK, slot));
          if (kind == REQ_DELETE) held[slot] = 1'b0;
        end
      end
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        mismatches++;
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      end
    endfunction

    function void check_result(logic [1:0] st, logic [SLOT_W-1:0] slot, logic [CODE_W-1:0] code,
                               logic [PRICE_W-1:0] price, logic [QTY_W-1:0] qty);
      table_reply_t want;
      if (replies_due.size() == 0) begin
        mismatches++;
        $error("result beat with no request outstanding");
        return;
      end
      want = replies_due.pop_front();
      compare_field("status", want.status, st);
      compare_field("slot_index", want.slot, slot);
      compare_field("code_out", want.code, code);
      compare_field("price_out", want.price, price);
      compare_field("quantity_out", want.qty, qty);
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    function int random_live_slot();
      int live_slots [$];
      foreach (held[s]) if (held[s]) live_slots.push_back(s);
      if (live_slots.size() == 0) return -1;
      return live_slots[$urandom_range(0, live_slots.size() - 1)];
    endfunction
  endclass

endpackage

// File: tb/tb.sv
`timescale 1ns / 1ps
// Top-level testbench for the slot record table: directed and random requests, checked per beat.
module tb;
  import srt_pkg::*;
  import table_scoreboard_pkg::*;

  localparam int DEPTH = SRT_TABLE_DEPTH;
  // Request types above set-quantity are unused; the block must answer them as not found.
  localparam int REQ_SPARE_LO = REQ_SET_QTY + 1;
  localparam int REQ_SPARE_HI = (1 << 3) - 1;
  localparam logic [PRICE_W-1:0] PRICE_TOP = 34'd9999999900;
  localparam logic [QTY_W-1:0]   QTY_TOP   = 10'd999;
  localparam int RANDOM_ITEMS = 1500;
  // The longest quiet stretch in a correct run is a sender gap plus a full scan of the table;
  // the watchdog allows many times that.
  localparam int IDLE_LIMIT = 1000;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         in_req_type = '0;
  logic [CODE_W-1:0]  in_product_code = '0;
  logic [PRICE_W-1:0] in_price = '0;
  logic [QTY_W-1:0]   in_quantity = '0;
  logic               out_valid;
  logic [1:0]         out_status;
  logic [SLOT_W-1:0]  out_slot_index;
  logic [CODE_W-1:0]  out_code_out;
  logic [PRICE_W-1:0] out_price_out;
  logic [QTY_W-1:0]   out_quantity_out;

  table_scoreboard sb = new();
  int quiet_cycles = 0;

  slot_record_table #(.TABLE_DEPTH(DEPTH)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_product_code  (in_product_code),
    .in_price         (in_price),
    .in_quantity      (in_quantity),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_slot_index   (out_slot_index),
    .out_code_out     (out_code_out),
    .out_price_out    (out_price_out),
    .out_quantity_out (out_quantity_out)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Everything is sampled at the rising edge, where the inputs driven at the falling edge are
  // settled and the block's registered outputs still show the cycle that is ending. A result
  // strobe and a new request can meet at the same edge, since the block takes a new beat in the
  // cycle of its strobe; the result is checked first, as it belongs to the earlier request.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1)
        sb.check_result(out_status, out_slot_index, out_code_out, out_price_out,
                        out_quantity_out);
      if (start && busy === 1'b0)
        sb.note_request(in_req_type, in_product_code, in_price, in_quantity);
    end
  end

  // The watchdog counts edges at which neither a request nor a result is accepted. A hung
  // scan, a lost strobe or a reply that never comes all end here.
  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one request from a falling edge and holds it until the block takes it. It returns
  // at the falling edge after the handshake with start still high, so that a following beat in
  // the same burst keeps start up without a dip.
  task automatic drive_beat(input logic [2:0] kind, input logic [CODE_W-1:0] code,
                            input logic [PRICE_W-1:0] price, input logic [QTY_W-1:0] qty);
    in_req_type     <= kind;
    in_product_code <= code;
    in_price        <= price;
    in_quantity     <= qty;
    start           <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  // One random request. The mix decides how the table fills: filling phases run it up to the
  // full condition, draining phases empty it again, and balanced ones churn the middle. Most
  // requests that search carry a code that is live, so that the hit paths at every slot are
  // exercised; the rest carry codes that were deleted, not yet handed out or plainly random.
  task automatic random_beat(input mix_t mix);
    int                 roll;
    int                 slot;
    int                 w_ins;
    int                 w_del;
    logic [2:0]         kind;
    logic [CODE_W-1:0]  code;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic [63:0]        wide;
    case (mix)
      MIX_FILL: begin
        w_ins = 60;
        w_del = 8;
      end
      MIX_DRAIN: begin
        w_ins = 15;
        w_del = 45;
      end
      default: begin
        w_ins = 30;
        w_del = 25;
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < w_ins) begin
      kind = REQ_INSERT;
    end else if (roll < w_ins + w_del) begin
      kind = REQ_DELETE;
    end else begin
      roll = $urandom_range(0, 19);
      if (roll < 7) kind = REQ_LOOKUP;
      else if (roll < 12) kind = REQ_SET_PRICE;
      else if (roll < 18) kind = REQ_SET_QTY;
      else kind = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
    end

    roll = $urandom_range(0, 99);
    slot = sb.random_live_slot();
    if (roll < 75 && slot >= 0) code = sb.held_code[slot];
    else if (roll < 90) code = $urandom_range(0, sb.code_counter);
    else code = $urandom;

    // Prices and quantities beyond their nominal range are stored unchecked, so the full
    // width of each field is driven now and then alongside the extremes of the range.
    wide = {$urandom, $urandom};
    roll = $urandom_range(0, 99);
    if (roll < 8) price = wide[PRICE_W-1:0];
    else if (roll < 10) price = '0;
    else if (roll < 12) price = '1;
    else if (roll < 14) price = PRICE_TOP;
    else price = PRICE_W'(wide % (64'(PRICE_TOP) + 64'd1));

    roll = $urandom_range(0, 99);
    if (roll < 10) qty = QTY_W'($urandom_range(0, (1 << QTY_W) - 1));
    else if (roll < 13) qty = QTY_TOP;
    else qty = QTY_W'($urandom_range(0, QTY_TOP));

    drive_beat(kind, code, price, qty);
  endtask

  initial begin
    int   sent;
    int   burst;
    int   gap;
    int   phase_left;
    mix_t mix;

    // Synchronous reset, held from the start and released at a falling edge.
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening: inserts with the field extremes (including values beyond the nominal
    // range), hits and misses of every search operation, a delete that reports the removed
    // entry, reuse of the lowest freed slot and every unused request type. Codes that repeat
    // after the counter wraps would take four thousand million inserts and are out of reach.
    drive_beat(REQ_INSERT, '1, '0, '0);
    drive_beat(REQ_INSERT, '0, '1, '1);
    drive_beat(REQ_INSERT, '1, PRICE_TOP, QTY_TOP);
    drive_beat(REQ_LOOKUP, 32'd0, '1, '1);
    drive_beat(REQ_LOOKUP, 32'd2, '0, '0);
    drive_beat(REQ_SET_PRICE, 32'd1, '0, '1);
    drive_beat(REQ_SET_QTY, 32'd1, '1, QTY_TOP);
    drive_beat(REQ_LOOKUP, 32'd1, '0, '0);
    drive_beat(REQ_DELETE, 32'd0, '0, '0);
    drive_beat(REQ_LOOKUP, 32'd0, '0, '0);
    drive_beat(REQ_DELETE, 32'd0, '0, '0);
    drive_beat(REQ_SET_PRICE, 32'd0, PRICE_TOP, '0);
    drive_beat(REQ_SET_QTY, '1, '0, QTY_TOP);
    drive_beat(REQ_INSERT, '0, PRICE_TOP, '0);
    drive_beat(REQ_LOOKUP, 32'd3, '0, '0);
    for (int k = REQ_SPARE_LO; k <= REQ_SPARE_HI; k++) drive_beat(3'(k), 32'd3, '1, '1);
    drive_beat(REQ_LOOKUP, '1, '0, '0);
    drive_beat(REQ_DELETE, 32'd2, '0, '0);
    drive_beat(REQ_SET_QTY, 32'd3, '1, '0);

    // Random part. The sender works in bursts with gaps between them; now and then a long
    // burst runs with no idling at all. The first phase fills the table, so the full answer
    // is seen early, and later phases pick their mix at random.
    sent       = 0;
    mix        = MIX_FILL;
    phase_left = 200;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) burst = $urandom_range(30, 60);
      else burst = $urandom_range(1, 8);
      for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
        if (phase_left == 0) begin
          mix        = mix_t'($urandom_range(MIX_FILL, MIX_BALANCED));
          phase_left = $urandom_range(60, 200);
        end
        random_beat(mix);
        sent++;
        phase_left--;
      end
      gap = $urandom_range(0, 24);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    start <= 1'b0;

    // Drain: wait for every reply, then watch for any stray strobe.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
